// ===== rtl/core/c8_pkg.sv =====
// Shared constants, payload types and control codes for the CHIP-8 core.
package c8_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int SCREEN_PIXELS = 2048;
	localparam int STACK_DEPTH   = 16;
	localparam int MEM_AW        = $clog2(MEM_BYTES);
	localparam int SCR_BYTES     = SCREEN_PIXELS / 8;
	localparam int SCR_AW        = $clog2(SCR_BYTES);
	localparam int SP_W          = 4;
	localparam int FONT_BYTES    = 80;

	localparam logic [11:0] PC_RESET = 12'h200;

	localparam logic [1:0] CMD_EXEC   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_SCREEN = 2'd3;

	localparam logic [4:0] U_CLR   = 5'd0;
	localparam logic [4:0] U_IDLE  = 5'd1;
	localparam logic [4:0] U_DISP  = 5'd2;
	localparam logic [4:0] U_F0    = 5'd3;
	localparam logic [4:0] U_F1    = 5'd4;
	localparam logic [4:0] U_F2    = 5'd5;
	localparam logic [4:0] U_F3    = 5'd6;
	localparam logic [4:0] U_F4    = 5'd7;
	localparam logic [4:0] U_F5    = 5'd8;
	localparam logic [4:0] U_EXEC  = 5'd9;
	localparam logic [4:0] U_WVF   = 5'd10;
	localparam logic [4:0] U_WVX   = 5'd11;
	localparam logic [4:0] U_CLS   = 5'd12;
	localparam logic [4:0] U_DRD   = 5'd13;
	localparam logic [4:0] U_DLD   = 5'd14;
	localparam logic [4:0] U_DCOL  = 5'd15;
	localparam logic [4:0] U_DWR   = 5'd16;
	localparam logic [4:0] U_BCD   = 5'd17;
	localparam logic [4:0] U_STRD  = 5'd18;
	localparam logic [4:0] U_STWR  = 5'd19;
	localparam logic [4:0] U_LDRD  = 5'd20;
	localparam logic [4:0] U_LDWR  = 5'd21;
	localparam logic [4:0] U_MW    = 5'd22;
	localparam logic [4:0] U_MR    = 5'd23;
	localparam logic [4:0] U_SR    = 5'd24;
	localparam logic [4:0] U_RDCAP = 5'd25;
	localparam logic [4:0] U_FIN   = 5'd26;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] key_state;
		logic [7:0]  random_byte;
		logic [11:0] address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] last_opcode;
		logic        draw_flag;
		logic        sound_on;
		logic        waiting_key;
		logic        unknown_opcode;
		logic [7:0]  read_data;
	} rsp_t;

	typedef struct packed {
		logic [4:0] uop;
		logic       take;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       k_cls;
		logic       k_draw;
		logic       k_bcd;
		logic       k_store;
		logic       k_load;
		logic       key_miss;
		logic       need_vf;
		logic       need_vx;
		logic       n_zero;
		logic       bit_set;
		logic       col_last;
		logic       row_last;
		logic       clr_done;
		logic       cls_done;
		logic       bcd_done;
		logic       blk_done;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/core/chip8_cpu_core.sv =====
// Top level of the CHIP-8 processor core.
// One transaction at a time: after reset the core loads the font and clears
// main memory, screen and V registers, holding req_stall high. A memory write
// passes through dispatch, write and finish, and a memory or screen read through
// dispatch, read, capture and finish; an instruction passes through fetch,
// register reads, execute and finish, plus V register write-back, the screen
// clear of 00E0, the sprite rows of DXYN, the register block of FX55/FX65 and
// the digits of FX33, all paced by the single-port memories.
// A finished result waits in an output register while the next command enters.
module chip8_cpu_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  c8_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output c8_pkg::rsp_t rsp
);
	import c8_pkg::*;

	ctl_t ctl;
	sts_t sts;

	c8_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .sts(sts),
		.ctl(ctl), .req_stall(req_stall)
	);

	c8_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp_stall(rsp_stall), .ctl(ctl),
		.sts(sts), .rsp_valid(rsp_valid), .rsp(rsp)
	);

endmodule

// ===== rtl/core/c8_ram.sv =====
// Generic single-port RAM with registered read.
module c8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/core/c8_ctrl.sv =====
// Sequencing state machine of the CHIP-8 core.
module c8_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  c8_pkg::sts_t sts,
	output c8_pkg::ctl_t ctl,
	output logic         req_stall
);
	import c8_pkg::*;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_CLR:  if (sts.clr_done) state_d = U_IDLE;
			U_IDLE: if (req_valid) state_d = U_DISP;
			U_DISP: begin
				case (sts.cmd)
					CMD_EXEC:  state_d = U_F0;
					CMD_WRITE: state_d = U_MW;
					CMD_READ:  state_d = U_MR;
					default:   state_d = U_SR;
				endcase
			end
			U_F0: state_d = U_F1;
			U_F1: state_d = U_F2;
			U_F2: state_d = U_F3;
			U_F3: state_d = U_F4;
			U_F4: state_d = U_F5;
			U_F5: state_d = U_EXEC;
			U_EXEC: begin
				if (sts.k_cls) state_d = U_CLS;
				else if (sts.k_draw) state_d = sts.n_zero ? U_WVF : U_DRD;
				else if (sts.k_bcd) state_d = U_BCD;
				else if (sts.k_store) state_d = U_STRD;
				else if (sts.k_load) state_d = U_LDRD;
				else if (sts.key_miss) state_d = U_FIN;
				else if (sts.need_vf) state_d = U_WVF;
				else if (sts.need_vx) state_d = U_WVX;
				else state_d = U_FIN;
			end
			U_WVF: state_d = sts.need_vx ? U_WVX : U_FIN;
			U_WVX: state_d = U_FIN;
			U_CLS: if (sts.cls_done) state_d = U_FIN;
			U_DRD: state_d = U_DLD;
			U_DLD: state_d = U_DCOL;
			U_DCOL: begin
				if (sts.bit_set) state_d = U_DWR;
				else if (sts.col_last) state_d = sts.row_last ? U_WVF : U_DRD;
			end
			U_DWR: begin
				if (sts.col_last) state_d = sts.row_last ? U_WVF : U_DRD;
				else state_d = U_DCOL;
			end
			U_BCD:  if (sts.bcd_done) state_d = U_FIN;
			U_STRD: state_d = U_STWR;
			U_STWR: state_d = sts.blk_done ? U_FIN : U_STRD;
			U_LDRD: state_d = U_LDWR;
			U_LDWR: state_d = sts.blk_done ? U_FIN : U_LDRD;
			U_MW:    state_d = U_FIN;
			U_MR:    state_d = U_RDCAP;
			U_SR:    state_d = U_RDCAP;
			U_RDCAP: state_d = U_FIN;
			U_FIN:   if (sts.out_free) state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	assign req_stall = (state_q != U_IDLE);
	assign ctl.uop   = state_q;
	assign ctl.take  = (state_q == U_IDLE) && req_valid;

endmodule

// ===== rtl/core/c8_dp.sv =====
// Datapath of the CHIP-8 core: architectural state, memories and result register.
module c8_dp (
	input  logic         clk,
	input  logic         arst_n,
	input  c8_pkg::req_t req,
	input  logic         rsp_stall,
	input  c8_pkg::ctl_t ctl,
	output c8_pkg::sts_t sts,
	output logic         rsp_valid,
	output c8_pkg::rsp_t rsp
);
	import c8_pkg::*;

	logic [11:0]     pc_q, i_q, cnt_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]      dt_q, st_q, flag_q;
	logic [15:0]     op_q;
	logic [11:0]     stk_q [STACK_DEPTH];
	logic [3:0]      row_q;
	logic [2:0]      col_q;
	logic            draw_q, wait_q, unk_q, rsp_valid_q;
	req_t            in_q;
	rsp_t            rsp_q;
	logic [7:0]      vx_q, vy_q, v0_q, res_q, spr_q, rdata_q;

	logic              mem_we, scr_we, vr_we;
	logic [MEM_AW-1:0] mem_addr;
	logic [SCR_AW-1:0] scr_addr;
	logic [3:0]        vr_addr;
	logic [7:0]        mem_wd, mem_rd, scr_wd, scr_rd, vr_wd, vr_rd;

	logic [3:0]  x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn;

	logic [11:0]     ex_pc, i_val;
	logic            known, need_vf, need_vx, k_cls, k_draw, k_bcd, k_store, k_load;
	logic            key_miss, push, pop, i_set, dt_set, st_set, keybit;
	logic [7:0]      res, vf;
	logic [3:0]      key_hi;
	logic [8:0]      sum;
	logic [SP_W-1:0] sp_inc, sp_dec;

	logic [7:0]  hund, rem, tens, ones, digit;
	logic [15:0] tprod;
	logic [4:0]  yr;
	logic [10:0] pix;
	logic [7:0]  mask;
	logic        out_free, fin_go, tick;
	logic [7:0]  st_next;

	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];

	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign sum    = {1'b0, vx_q} + {1'b0, vy_q};
	assign keybit = in_q.key_state[vx_q[3:0]];

	always_comb begin
		ex_pc    = pc_q + 12'd2;
		known    = 1'b1;
		need_vf  = 1'b0;
		need_vx  = 1'b0;
		res      = 8'd0;
		vf       = 8'd0;
		k_cls    = 1'b0;
		k_draw   = 1'b0;
		k_bcd    = 1'b0;
		k_store  = 1'b0;
		k_load   = 1'b0;
		key_miss = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		i_set    = 1'b0;
		i_val    = i_q;
		dt_set   = 1'b0;
		st_set   = 1'b0;
		key_hi   = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (in_q.key_state[k]) key_hi = 4'(k);
		end
		case (op_q[15:12])
			4'h0: begin
				if (op_q == 16'h00E0) k_cls = 1'b1;
				else if (op_q == 16'h00EE) begin
					pop   = 1'b1;
					ex_pc = stk_q[sp_dec] + 12'd2;
				end else known = 1'b0;
			end
			4'h1: ex_pc = nnn;
			4'h2: begin
				push  = 1'b1;
				ex_pc = nnn;
			end
			4'h3: if (vx_q == nn) ex_pc = pc_q + 12'd4;
			4'h4: if (vx_q != nn) ex_pc = pc_q + 12'd4;
			4'h5: if (vx_q == vy_q) ex_pc = pc_q + 12'd4;
			4'h6: begin
				res     = nn;
				need_vx = 1'b1;
			end
			4'h7: begin
				res     = vx_q + nn;
				need_vx = 1'b1;
			end
			4'h8: begin
				need_vx = 1'b1;
				case (n)
					4'h0: res = vy_q;
					4'h1: res = vx_q | vy_q;
					4'h2: res = vx_q & vy_q;
					4'h3: res = vx_q ^ vy_q;
					4'h4: begin
						res     = sum[7:0];
						vf      = {7'd0, sum[8]};
						need_vf = 1'b1;
					end
					4'h5: begin
						res     = vx_q - vy_q;
						vf      = {7'd0, vx_q >= vy_q};
						need_vf = 1'b1;
					end
					4'h6: begin
						res     = {1'b0, vy_q[7:1]};
						vf      = {7'd0, vy_q[0]};
						need_vf = 1'b1;
					end
					4'h7: begin
						res     = vy_q - vx_q;
						vf      = {7'd0, vy_q >= vx_q};
						need_vf = 1'b1;
					end
					4'hE: begin
						res     = {vy_q[6:0], 1'b0};
						vf      = {7'd0, vy_q[7]};
						need_vf = 1'b1;
					end
					default: begin
						known   = 1'b0;
						need_vx = 1'b0;
					end
				endcase
			end
			4'h9: if (vx_q != vy_q) ex_pc = pc_q + 12'd4;
			4'hA: begin
				i_set = 1'b1;
				i_val = nnn;
			end
			4'hB: ex_pc = nnn + {4'd0, v0_q};
			4'hC: begin
				res     = in_q.random_byte & nn;
				need_vx = 1'b1;
			end
			4'hD: k_draw = 1'b1;
			4'hE: begin
				if (nn == 8'h9E) begin
					if (keybit) ex_pc = pc_q + 12'd4;
				end else if (nn == 8'hA1) begin
					if (!keybit) ex_pc = pc_q + 12'd4;
				end else known = 1'b0;
			end
			default: begin
				case (nn)
					8'h07: begin
						res     = dt_q;
						need_vx = 1'b1;
					end
					8'h0A: begin
						if (in_q.key_state == 16'd0) key_miss = 1'b1;
						else begin
							res     = {4'd0, key_hi};
							need_vx = 1'b1;
						end
					end
					8'h15: dt_set = 1'b1;
					8'h18: st_set = 1'b1;
					8'h1E: begin
						i_set = 1'b1;
						i_val = i_q + {4'd0, vx_q};
					end
					8'h29: begin
						i_set = 1'b1;
						i_val = 12'({4'd0, vx_q} * 12'd5);
					end
					8'h33: k_bcd = 1'b1;
					8'h55: k_store = 1'b1;
					8'h65: k_load = 1'b1;
					default: known = 1'b0;
				endcase
			end
		endcase
	end

	always_comb begin
		if (vx_q >= 8'd200) hund = 8'd2;
		else if (vx_q >= 8'd100) hund = 8'd1;
		else hund = 8'd0;
		rem   = vx_q - 8'(hund * 8'd100);
		tprod = {8'd0, rem} * 16'd205;
		tens  = {3'd0, tprod[15:11]};
		ones  = rem - 8'(tens * 8'd10);
		case (cnt_q[1:0])
			2'd0:    digit = hund;
			2'd1:    digit = tens;
			default: digit = ones;
		endcase
	end

	assign yr   = vy_q[4:0] + {1'b0, row_q};
	assign pix  = {yr, 6'd0} + {3'd0, vx_q} + {8'd0, col_q};
	assign mask = 8'h80 >> pix[2:0];

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = pc_q;
		mem_wd   = in_q.write_data;
		scr_we   = 1'b0;
		scr_addr = pix[10:3];
		scr_wd   = 8'd0;
		vr_we    = 1'b0;
		vr_addr  = x;
		vr_wd    = res_q;
		case (ctl.uop)
			U_CLR: begin
				mem_we   = 1'b1;
				mem_addr = cnt_q;
				mem_wd   = (cnt_q < 12'(FONT_BYTES)) ? FONT[cnt_q[6:0]] : 8'd0;
				scr_we   = 1'b1;
				scr_addr = cnt_q[SCR_AW-1:0];
				vr_we    = 1'b1;
				vr_addr  = cnt_q[3:0];
				vr_wd    = 8'd0;
			end
			U_F1: mem_addr = pc_q + 12'd1;
			U_F3: vr_addr = y;
			U_F4: vr_addr = 4'd0;
			U_WVF: begin
				vr_we   = 1'b1;
				vr_addr = 4'hF;
				vr_wd   = flag_q;
			end
			U_WVX: vr_we = 1'b1;
			U_CLS: begin
				scr_we   = 1'b1;
				scr_addr = cnt_q[SCR_AW-1:0];
			end
			U_DRD: mem_addr = i_q + {8'd0, row_q};
			U_DWR: begin
				scr_we = 1'b1;
				scr_wd = scr_rd ^ mask;
			end
			U_BCD: begin
				mem_we   = 1'b1;
				mem_addr = i_q + cnt_q;
				mem_wd   = digit;
			end
			U_STRD: vr_addr = cnt_q[3:0];
			U_STWR: begin
				mem_we   = 1'b1;
				mem_addr = i_q + cnt_q;
				mem_wd   = vr_rd;
			end
			U_LDRD: mem_addr = i_q + cnt_q;
			U_LDWR: begin
				vr_we   = 1'b1;
				vr_addr = cnt_q[3:0];
				vr_wd   = mem_rd;
			end
			U_MW: begin
				mem_we   = 1'b1;
				mem_addr = in_q.address;
			end
			U_MR: mem_addr = in_q.address;
			U_SR: scr_addr = in_q.address[SCR_AW-1:0];
			default: ;
		endcase
	end

	c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_rd)
	);

	c8_ram #(.WIDTH(8), .DEPTH(SCR_BYTES)) u_scr (
		.clk(clk), .we(scr_we), .addr(scr_addr), .wdata(scr_wd), .rdata(scr_rd)
	);

	c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
		.clk(clk), .we(vr_we), .addr(vr_addr), .wdata(vr_wd), .rdata(vr_rd)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fin_go   = (ctl.uop == U_FIN) && out_free;
	assign tick     = (in_q.cmd == CMD_EXEC) && !wait_q;
	assign st_next  = (tick && st_q != 8'd0) ? st_q - 8'd1 : st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_RESET;
			i_q         <= '0;
			sp_q        <= '0;
			dt_q        <= '0;
			st_q        <= '0;
			op_q        <= '0;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			flag_q      <= '0;
			draw_q      <= 1'b0;
			wait_q      <= 1'b0;
			unk_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int k = 0; k < STACK_DEPTH; k++) begin
				stk_q[k] <= '0;
			end
		end else begin
			if (ctl.take) begin
				draw_q <= 1'b0;
				wait_q <= 1'b0;
				unk_q  <= 1'b0;
				cnt_q  <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end
			case (ctl.uop)
				U_CLR, U_CLS, U_BCD: cnt_q <= cnt_q + 12'd1;
				U_F1: op_q[15:8] <= mem_rd;
				U_F2: op_q[7:0] <= mem_rd;
				U_EXEC: begin
					if (known && !key_miss) pc_q <= ex_pc;
					unk_q  <= !known;
					wait_q <= key_miss;
					draw_q <= k_cls || k_draw;
					flag_q <= vf;
					if (i_set) i_q <= i_val;
					if (dt_set) dt_q <= vx_q;
					if (st_set) st_q <= vx_q;
					if (push) begin
						stk_q[sp_q] <= pc_q;
						sp_q        <= sp_inc;
					end
					if (pop) sp_q <= sp_dec;
				end
				U_DLD: col_q <= '0;
				U_DCOL: begin
					if (!sts.bit_set) begin
						col_q <= col_q + 3'd1;
						if (sts.col_last) row_q <= row_q + 4'd1;
					end
				end
				U_DWR: begin
					flag_q <= flag_q | {7'd0, |(scr_rd & mask)};
					col_q  <= col_q + 3'd1;
					if (sts.col_last) row_q <= row_q + 4'd1;
				end
				U_STWR, U_LDWR: begin
					cnt_q <= cnt_q + 12'd1;
					if (sts.blk_done) i_q <= i_q + {8'd0, x} + 12'd1;
				end
				U_FIN: begin
					if (out_free && tick) begin
						st_q <= st_next;
						if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
					end
				end
				default: ;
			endcase
			if (fin_go) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			in_q    <= req;
			rdata_q <= 8'd0;
		end
		case (ctl.uop)
			U_F3:   vx_q <= vr_rd;
			U_F4:   vy_q <= vr_rd;
			U_F5:   v0_q <= vr_rd;
			U_EXEC: res_q <= res;
			U_DLD:  spr_q <= mem_rd;
			U_RDCAP: rdata_q <= (in_q.cmd == CMD_READ) ? mem_rd : scr_rd;
			default: ;
		endcase
		if (fin_go) begin
			rsp_q.program_counter <= pc_q;
			rsp_q.last_opcode     <= op_q;
			rsp_q.draw_flag       <= draw_q;
			rsp_q.sound_on        <= (st_next != 8'd0);
			rsp_q.waiting_key     <= wait_q;
			rsp_q.unknown_opcode  <= unk_q;
			rsp_q.read_data       <= rdata_q;
		end
	end

	assign sts.cmd      = in_q.cmd;
	assign sts.k_cls    = k_cls;
	assign sts.k_draw   = k_draw;
	assign sts.k_bcd    = k_bcd;
	assign sts.k_store  = k_store;
	assign sts.k_load   = k_load;
	assign sts.key_miss = key_miss;
	assign sts.need_vf  = need_vf;
	assign sts.need_vx  = need_vx;
	assign sts.n_zero   = (n == 4'd0);
	assign sts.bit_set  = spr_q[3'd7 - col_q];
	assign sts.col_last = (col_q == 3'd7);
	assign sts.row_last = (row_q == n - 4'd1);
	assign sts.clr_done = (cnt_q == 12'(MEM_BYTES - 1));
	assign sts.cls_done = (cnt_q[SCR_AW-1:0] == SCR_AW'(SCR_BYTES - 1));
	assign sts.bcd_done = (cnt_q[1:0] == 2'd2);
	assign sts.blk_done = (cnt_q[3:0] == x);
	assign sts.out_free = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/chip8_cpu_core_tb.sv =====
// Self-checking testbench for the CHIP-8 core: directed table, then random programs.
`timescale 1ns / 1ps

module testbench;
	import c8_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	chip8_cpu_core dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// CPU state mirror
	logic [7:0]  ram [MEM_BYTES];
	logic        pix [SCREEN_PIXELS];
	logic [7:0]  vreg [16];
	logic [11:0] ret_stack [16];
	logic [3:0]  sp;
	logic [11:0] pc, idx_reg;
	logic [7:0]  delay_t, sound_t;
	logic [15:0] last_op;

	rsp_t expected_rsp [$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	typedef struct {
		bit          is_op;
		req_t        r;
		logic [15:0] word;
		bit          typed;
		logic [7:0]  rd;
	} row_t;

	row_t dir_rows [$];

	task automatic cpu_reset();
		for (int a = 0; a < MEM_BYTES; a++) ram[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
		for (int a = 0; a < SCREEN_PIXELS; a++) pix[a] = 1'b0;
		for (int a = 0; a < 16; a++) begin
			vreg[a] = '0;
			ret_stack[a] = '0;
		end
		sp = '0;
		pc = PC_RESET;
		idx_reg = '0;
		delay_t = '0;
		sound_t = '0;
		last_op = '0;
	endtask

	task automatic cpu_step(input req_t r, output rsp_t o);
		logic [15:0] op;
		logic [3:0]  nx, ny, nl;
		logic [7:0]  nn, vx, vy, bits;
		logic [11:0] nnn, npc, a;
		logic [8:0]  sum;
		bit known, hit, stuck;
		int p;
		o = '0;
		known = 1;
		stuck = 0;
		if (r.cmd == CMD_EXEC) begin
			op = {ram[pc], ram[pc + 12'd1]};
			nx = op[11:8];
			ny = op[7:4];
			nl = op[3:0];
			nn = op[7:0];
			nnn = op[11:0];
			vx = vreg[nx];
			vy = vreg[ny];
			npc = pc + 12'd2;
			last_op = op;
			case (op[15:12])
				4'h0: begin
					if (op == 16'h00E0) begin
						for (int k = 0; k < SCREEN_PIXELS; k++) pix[k] = 1'b0;
						o.draw_flag = 1'b1;
					end else if (op == 16'h00EE) begin
						sp = sp - 4'd1;
						npc = ret_stack[sp] + 12'd2;
					end else known = 0;
				end
				4'h1: npc = nnn;
				4'h2: begin
					ret_stack[sp] = pc;
					sp = sp + 4'd1;
					npc = nnn;
				end
				4'h3: if (vx == nn) npc = npc + 12'd2;
				4'h4: if (vx != nn) npc = npc + 12'd2;
				4'h5: if (vx == vy) npc = npc + 12'd2;
				4'h6: vreg[nx] = nn;
				4'h7: vreg[nx] = vx + nn;
				4'h8: begin
					case (nl)
						4'h0: vreg[nx] = vy;
						4'h1: vreg[nx] = vx | vy;
						4'h2: vreg[nx] = vx & vy;
						4'h3: vreg[nx] = vx ^ vy;
						4'h4: begin
							sum = {1'b0, vx} + {1'b0, vy};
							vreg[15] = {7'd0, sum[8]};
							vreg[nx] = sum[7:0];
						end
						4'h5: begin
							vreg[15] = (vy > vx) ? 8'd0 : 8'd1;
							vreg[nx] = vx - vy;
						end
						4'h6: begin
							vreg[15] = {7'd0, vy[0]};
							vreg[nx] = vy >> 1;
						end
						4'h7: begin
							vreg[15] = (vx > vy) ? 8'd0 : 8'd1;
							vreg[nx] = vy - vx;
						end
						4'hE: begin
							vreg[15] = {7'd0, vy[7]};
							vreg[nx] = vy << 1;
						end
						default: known = 0;
					endcase
				end
				4'h9: if (vx != vy) npc = npc + 12'd2;
				4'hA: idx_reg = nnn;
				4'hB: npc = nnn + {4'd0, vreg[0]};
				4'hC: vreg[nx] = r.random_byte & nn;
				4'hD: begin
					vreg[15] = 8'd0;
					for (int row = 0; row < nl; row++) begin
						a = idx_reg + row[11:0];
						bits = ram[a];
						for (int col = 0; col < 8; col++) begin
							if (bits[7 - col]) begin
								p = (vx + col + (vy + row) * 64) % SCREEN_PIXELS;
								if (pix[p]) vreg[15] = 8'd1;
								pix[p] = ~pix[p];
							end
						end
					end
					o.draw_flag = 1'b1;
				end
				4'hE: begin
					if (nn == 8'h9E) begin
						if (r.key_state[vx[3:0]]) npc = npc + 12'd2;
					end else if (nn == 8'hA1) begin
						if (!r.key_state[vx[3:0]]) npc = npc + 12'd2;
					end else known = 0;
				end
				default: begin
					case (nn)
						8'h07: vreg[nx] = delay_t;
						8'h0A: begin
							hit = 0;
							for (int k = 0; k < 16; k++) begin
								if (r.key_state[k]) begin
									vreg[nx] = k[7:0];
									hit = 1;
								end
							end
							if (!hit) stuck = 1;
						end
						8'h15: delay_t = vx;
						8'h18: sound_t = vx;
						8'h1E: idx_reg = idx_reg + {4'd0, vx};
						8'h29: idx_reg = {4'd0, vx} * 12'd5;
						8'h33: begin
							ram[idx_reg] = vx / 100;
							ram[idx_reg + 12'd1] = (vx / 10) % 10;
							ram[idx_reg + 12'd2] = vx % 10;
						end
						8'h55: begin
							for (int k = 0; k <= nx; k++) ram[idx_reg + k[11:0]] = vreg[k];
							idx_reg = idx_reg + {8'd0, nx} + 12'd1;
						end
						8'h65: begin
							for (int k = 0; k <= nx; k++) vreg[k] = ram[idx_reg + k[11:0]];
							idx_reg = idx_reg + {8'd0, nx} + 12'd1;
						end
						default: known = 0;
					endcase
				end
			endcase
			if (stuck) begin
				o.waiting_key = 1'b1;
			end else begin
				if (known) pc = npc;
				else o.unknown_opcode = 1'b1;
				if (delay_t != 0) delay_t = delay_t - 8'd1;
				if (sound_t != 0) sound_t = sound_t - 8'd1;
			end
		end else if (r.cmd == CMD_WRITE) begin
			ram[r.address] = r.write_data;
		end else if (r.cmd == CMD_READ) begin
			o.read_data = ram[r.address];
		end else begin
			for (int k = 0; k < 8; k++) o.read_data[7 - k] = pix[r.address[7:0] * 8 + k];
		end
		o.program_counter = pc;
		o.last_opcode = last_op;
		o.sound_on = (sound_t != 0);
	endtask

	function automatic req_t mk(logic [1:0] c, logic [15:0] keys, logic [7:0] rnd,
			logic [11:0] addr, logic [7:0] data);
		req_t r;
		r.cmd = c;
		r.key_state = keys;
		r.random_byte = rnd;
		r.address = addr;
		r.write_data = data;
		return r;
	endfunction

	function automatic req_t rand_req(logic [1:0] c);
		return mk(c, ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom),
			8'($urandom), 12'($urandom), 8'($urandom));
	endfunction

	// drop valid during random gaps, hold it through stalls, update the mirror on acceptance
	task automatic send(input req_t r, input bit typed, input logic [7:0] rd);
		rsp_t o;
		rsp_t t;
		bit acc;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			req <= rand_req(2'($urandom));
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			acc = !req_stall;
			@(posedge clk);
		end while (!acc);
		cpu_step(r, o);
		if (typed) begin
			t = '0;
			t.program_counter = PC_RESET;
			t.read_data = rd;
			expected_rsp.push_back(t);
		end else begin
			expected_rsp.push_back(o);
		end
	endtask

	task automatic run_instr(input logic [15:0] word, input logic [15:0] keys,
			input logic [7:0] rnd);
		send(mk(CMD_WRITE, keys, rnd, pc, word[15:8]), 0, 8'd0);
		send(mk(CMD_WRITE, keys, rnd, pc + 12'd1, word[7:0]), 0, 8'd0);
		send(mk(CMD_EXEC, keys, rnd, 12'($urandom), 8'($urandom)), 0, 8'd0);
	endtask

	function automatic logic [15:0] rand_word();
		logic [15:0] w;
		logic [7:0] f_ops [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55,
			8'h65};
		w = 16'($urandom);
		case (w[15:12])
			4'h0: begin
				case ($urandom_range(0, 9))
					0: w = 16'h00E0;
					1, 2, 3, 4: w = 16'h00EE;
					default: ;
				endcase
			end
			4'hE: if ($urandom_range(0, 3) != 0) w[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
			4'hF: if ($urandom_range(0, 7) != 0) w[7:0] = f_ops[$urandom_range(0, 8)];
			default: ;
		endcase
		return w;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected transaction: %p", rsp);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.program_counter !== e.program_counter) begin
					$error("program_counter expected %h got %h", e.program_counter,
						rsp.program_counter);
					errors++;
				end
				if (rsp.last_opcode !== e.last_opcode) begin
					$error("last_opcode expected %h got %h", e.last_opcode, rsp.last_opcode);
					errors++;
				end
				if (rsp.draw_flag !== e.draw_flag) begin
					$error("draw_flag expected %b got %b", e.draw_flag, rsp.draw_flag);
					errors++;
				end
				if (rsp.sound_on !== e.sound_on) begin
					$error("sound_on expected %b got %b", e.sound_on, rsp.sound_on);
					errors++;
				end
				if (rsp.waiting_key !== e.waiting_key) begin
					$error("waiting_key expected %b got %b", e.waiting_key, rsp.waiting_key);
					errors++;
				end
				if (rsp.unknown_opcode !== e.unknown_opcode) begin
					$error("unknown_opcode expected %b got %b", e.unknown_opcode,
						rsp.unknown_opcode);
					errors++;
				end
				if (rsp.read_data !== e.read_data) begin
					$error("read_data expected %h got %h", e.read_data, rsp.read_data);
					errors++;
				end
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int drain;
		cpu_reset();
		dir_rows = '{
			'{0, mk(CMD_READ, 16'h0000, 8'h00, 12'h000, 8'h00), 16'h0000, 1, 8'hF0},
			'{0, mk(CMD_READ, 16'hFFFF, 8'hFF, 12'd79, 8'hFF), 16'h0000, 1, 8'h80},
			'{0, mk(CMD_WRITE, 16'h0000, 8'h00, 12'hFFF, 8'hFF), 16'h0000, 1, 8'h00},
			'{0, mk(CMD_READ, 16'h0000, 8'h00, 12'hFFF, 8'h00), 16'h0000, 1, 8'hFF},
			'{0, mk(CMD_SCREEN, 16'h0000, 8'h00, 12'hFFF, 8'h00), 16'h0000, 1, 8'h00},
			'{1, '0, 16'h00E0, 0, 8'h00},
			'{1, '0, 16'h0123, 0, 8'h00},
			'{1, mk(CMD_EXEC, 16'h0000, 8'hFF, 12'h000, 8'h00), 16'hC0FF, 0, 8'h00},
			'{1, '0, 16'h6105, 0, 8'h00},
			'{1, '0, 16'hD015, 0, 8'h00},
			'{1, '0, 16'hD015, 0, 8'h00},
			'{1, '0, 16'h8F14, 0, 8'h00},
			'{1, mk(CMD_EXEC, 16'h0000, 8'h00, 12'h000, 8'h00), 16'hF20A, 0, 8'h00},
			'{1, mk(CMD_EXEC, 16'hFFFF, 8'h00, 12'h000, 8'h00), 16'hF20A, 0, 8'h00},
			'{1, '0, 16'hF218, 0, 8'h00},
			'{1, '0, 16'h2FFE, 0, 8'h00},
			'{1, '0, 16'h00EE, 0, 8'h00}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_op)
				run_instr(dir_rows[i].word, dir_rows[i].r.key_state, dir_rows[i].r.random_byte);
			else
				send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].rd);
		end
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase = (sent / 100) % 4;
			idle_pct = (phase == 1) ? 45 : (phase == 3) ? 7 : 0;
			stall_pct = (phase == 2) ? 45 : (phase == 3) ? 7 : 0;
			if ($urandom_range(0, 99) < 15) begin
				send(rand_req(2'($urandom_range(1, 3))), 0, 8'd0);
				sent += 1;
			end else begin
				run_instr(rand_word(), ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom),
					8'($urandom));
				sent += 3;
			end
		end
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		drain = 0;
		while (drain < 50) begin
			@(posedge clk);
			drain++;
		end
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== chip8_cpu_core.f =====
rtl/core/c8_pkg.sv
rtl/core/c8_ram.sv
rtl/core/c8_ctrl.sv
rtl/core/c8_dp.sv
rtl/core/chip8_cpu_core.sv
verif/chip8_cpu_core_tb.sv
